/* rtl/gfs_pkg.sv */
package gfs_pkg;

  localparam int ID_W    = 32;
  localparam int TIME_W  = 32;
  localparam int LT_W    = 21;
  localparam int SENDS_W = 8;
  localparam int RAND_W  = 16;

  // results per tick
  localparam logic [4:0] MAX_RESULTS = 5'd16;
  // divisor of the backoff scaling
  localparam logic [16:0] RAND_DIV = 17'd65535;

  typedef enum logic [2:0] {
    EV_SENT       = 3'd0,
    EV_SUPPRESSED = 3'd1,
    EV_HELD       = 3'd2,
    EV_EXPIRED    = 3'd3,
    EV_DELIVER    = 3'd4,
    EV_DUPLICATE  = 3'd5,
    EV_FULL       = 3'd6,
    EV_DEAD       = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_LOCAL   = 2'd1,
    REQ_RECEIVE = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  // configuration register indexes
  localparam logic [2:0] CFG_PERIOD   = 3'd0;
  localparam logic [2:0] CFG_MAX_BC   = 3'd1;
  localparam logic [2:0] CFG_PROB     = 3'd2;
  localparam logic [2:0] CFG_HOLD     = 3'd3;
  localparam logic [2:0] CFG_MAX_FB   = 3'd4;
  localparam logic [2:0] CFG_LIFETIME = 3'd5;

  // running search result handed from cell to cell
  typedef struct packed {
    logic                     has_best;
    logic [TIME_W-1:0]        age;
    logic [TIME_W-1:0]        ord;
    logic [ID_W-1:0]          id;
    logic signed [LT_W-1:0]   lt;
    logic [SENDS_W-1:0]       sends;
    logic                     is_local;
    logic                     match;
    logic                     has_free;
  } chain_t;

  // entry write broadcast to all cells
  typedef struct packed {
    logic                     en;
    logic                     valid;
    logic                     keep_order;
    logic [ID_W-1:0]          id;
    logic [TIME_W-1:0]        due;
    logic [TIME_W-1:0]        order;
    logic signed [LT_W-1:0]   lt;
    logic [SENDS_W-1:0]       sends;
    logic                     is_local;
  } wr_t;

endpackage

/* rtl/gfs_ifs.sv */
interface gfs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [31:0]        msg_id;
  logic signed [20:0] lifetime_in;
  logic [15:0]        rand_backoff;
  logic [15:0]        rand_coin;

  modport source (output valid, req_type, msg_id, lifetime_in, rand_backoff, rand_coin,
                  input ready);
  modport sink (input valid, req_type, msg_id, lifetime_in, rand_backoff, rand_coin,
                output ready);
endinterface

interface gfs_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_code;
  logic [31:0]        msg_out_id;
  logic signed [20:0] lifetime_out;
  logic               last_result;

  modport source (output valid, event_code, msg_out_id, lifetime_out, last_result,
                  input ready);
  modport sink (input valid, event_code, msg_out_id, lifetime_out, last_result,
                output ready);
endinterface

/* rtl/gfs_cell.sv */
module gfs_cell import gfs_pkg::*; #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  wr_t                 wr,
  input  logic [IW-1:0]       wr_idx,
  input  logic [TIME_W-1:0]   now,
  input  logic [TIME_W-1:0]   icnt,
  input  logic [ID_W-1:0]     qid,
  input  chain_t              prev,
  input  logic [IW-1:0]       prev_best_idx,
  input  logic [IW-1:0]       prev_free_idx,
  output chain_t              next,
  output logic [IW-1:0]       next_best_idx,
  output logic [IW-1:0]       next_free_idx
);

  logic                   valid;
  logic [ID_W-1:0]        id;
  logic [TIME_W-1:0]      due;
  logic [TIME_W-1:0]      order;
  logic signed [LT_W-1:0] lt;
  logic [SENDS_W-1:0]     sends;
  logic                   is_local;

  logic [TIME_W-1:0] age;
  logic [TIME_W-1:0] ord;
  logic              better;
  logic              take_free;
  logic              hit;

  chain_t            next_c;
  logic [IW-1:0]     best_idx_next;
  logic [IW-1:0]     free_idx_next;

  // entry storage, written by index
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && wr_idx == IW'(IDX)) begin
      valid <= wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr_idx == IW'(IDX)) begin
      id       <= wr.id;
      due      <= wr.due;
      lt       <= wr.lt;
      sends    <= wr.sends;
      is_local <= wr.is_local;
      if (!wr.keep_order) begin
        order <= wr.order;
      end
    end
  end

  // compare against the running best: older due first, then older insertion
  always_comb begin
    age       = now - due;
    ord       = icnt - order;
    better    = valid && !age[TIME_W-1] &&
                (!prev.has_best || age > prev.age || (age == prev.age && ord > prev.ord));
    take_free = !prev.has_free && !valid;
    hit       = valid && id == qid;

    next_c        = prev;
    best_idx_next = prev_best_idx;
    free_idx_next = prev_free_idx;
    next_c.match  = prev.match | hit;
    if (better) begin
      next_c.has_best = 1'b1;
      next_c.age      = age;
      next_c.ord      = ord;
      next_c.id       = id;
      next_c.lt       = lt;
      next_c.sends    = sends;
      next_c.is_local = is_local;
      best_idx_next   = IW'(IDX);
    end
    if (take_free) begin
      next_c.has_free = 1'b1;
      free_idx_next   = IW'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    next          <= next_c;
    next_best_idx <= best_idx_next;
    next_free_idx <= free_idx_next;
  end

endmodule

/* rtl/gossip_forward_scheduler_core.sv */
// Gossip forward scheduler: a time-ordered table of pending broadcasts.
// in_ch carries one request per transaction: a tick, a local originate or a
// received message. out_ch carries result transactions; last_result marks the
// final result of a request. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce. The table is a row of
// TABLE_DEPTH cells; a search result ripples through the row one cell per
// cycle. Originate and receive requests run one table search each; a tick
// runs one search for each entry it pops (at most 16) and one final search.
// A received message that finds the table full gives its FULL result and
// then its DELIVER result from a flush state.
// One request is worked on at a time; the next request is accepted as soon
// as the previous one has handed its last result to the output register.
// Reset empties the table, clears the tick clock and insertion counter and
// loads the default configuration. When out_ch stalls, the block holds its
// pending result and waits before making the next one.
module gossip_forward_scheduler_core import gfs_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  gfs_in_if.sink      in_ch,
  gfs_out_if.source   out_ch
);

  localparam int IW = $clog2(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_FLUSH  = 4'b1000
  } state_t;

  state_t state;

  // configuration
  logic [15:0] period;
  logic [7:0]  max_bc;
  logic [16:0] prob;
  logic [15:0] hold;
  logic [15:0] max_fb;
  logic [19:0] init_lt;

  // latched request
  req_t                   q_req;
  logic [ID_W-1:0]        q_id;
  logic signed [LT_W-1:0] q_lt;
  logic [RAND_W-1:0]      q_rb;
  logic [RAND_W-1:0]      q_rc;

  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] icnt;
  logic [IW-1:0]     scan_cnt;
  logic [4:0]        n_res;
  logic [31:0]       prod;

  // result waiting for its successor to settle last_result
  logic                   pend_valid;
  event_t                 pend_code;
  logic [ID_W-1:0]        pend_id;
  logic signed [LT_W-1:0] pend_lt;

  // output register
  logic                   out_valid;
  event_t                 out_code;
  logic [ID_W-1:0]        out_id;
  logic signed [LT_W-1:0] out_lt;
  logic                   out_last;

  chain_t        link [TABLE_DEPTH];
  logic [IW-1:0] link_best [TABLE_DEPTH];
  logic [IW-1:0] link_free [TABLE_DEPTH];
  chain_t        fin;
  logic [IW-1:0] fin_best;
  logic [IW-1:0] fin_free;

  wr_t           wr;
  logic [IW-1:0] wr_idx;

  // cell row
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      gfs_cell #(.IW(IW), .IDX(i)) u_cell (
        .clk, .rst, .wr, .wr_idx, .now, .icnt, .qid(q_id),
        .prev('0), .prev_best_idx('0), .prev_free_idx('0),
        .next(link[i]), .next_best_idx(link_best[i]), .next_free_idx(link_free[i])
      );
    end else begin : g_body
      gfs_cell #(.IW(IW), .IDX(i)) u_cell (
        .clk, .rst, .wr, .wr_idx, .now, .icnt, .qid(q_id),
        .prev(link[i-1]), .prev_best_idx(link_best[i-1]), .prev_free_idx(link_free[i-1]),
        .next(link[i]), .next_best_idx(link_best[i]), .next_free_idx(link_free[i])
      );
    end
  end

  assign fin      = link[TABLE_DEPTH-1];
  assign fin_best = link_best[TABLE_DEPTH-1];
  assign fin_free = link_free[TABLE_DEPTH-1];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      period  <= 16'd1000;
      max_bc  <= 8'd1;
      prob    <= 17'd32768;
      hold    <= 16'd1000;
      max_fb  <= 16'd1000;
      init_lt <= 20'd10000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIOD:   period  <= cfg_data[15:0];
        CFG_MAX_BC:   max_bc  <= cfg_data[7:0];
        CFG_PROB:     prob    <= cfg_data[16:0];
        CFG_HOLD:     hold    <= cfg_data[15:0];
        CFG_MAX_FB:   max_fb  <= cfg_data[15:0];
        CFG_LIFETIME: init_lt <= cfg_data;
        default: ;
      endcase
    end
  end

  // first backoff: bound * rand / 65535
  logic [15:0]            period_eff;
  logic [15:0]            bound_a;
  logic [15:0]            bound;
  logic signed [LT_W-1:0] lt_use;
  logic [15:0]            q0;
  logic [16:0]            rem;
  logic [15:0]            back;

  always_comb begin
    period_eff = (period == 16'd0) ? 16'd1 : period;
    bound_a    = (max_fb < period_eff) ? max_fb : period_eff;
    lt_use     = (q_req == REQ_LOCAL) ? $signed({1'b0, init_lt}) : q_lt;
    bound      = (!lt_use[LT_W-1] && lt_use < $signed({5'd0, bound_a})) ?
                 lt_use[15:0] : bound_a;
    q0         = prod[31:16];
    rem        = {1'b0, prod[15:0]} + {1'b0, q0};
    back       = q0 + 16'(rem >= RAND_DIV);
  end

  always_ff @(posedge clk) begin
    prod <= 32'(bound) * 32'(q_rb);
  end

  // decision on the finished search
  logic                   ok;
  logic                   go;
  logic                   need_emit;
  logic                   emit;
  event_t                 em_code;
  logic [ID_W-1:0]        em_id;
  logic signed [LT_W-1:0] em_lt;
  logic                   em_last;
  logic                   more;
  logic                   to_flush;
  logic                   do_insert;
  event_t                 pop_code;
  logic [LT_W-1:0]        delay;
  logic                   send;
  logic                   lt_dead;

  always_comb begin
    ok        = !out_valid || out_ch.ready;
    need_emit = 1'b0;
    em_code   = EV_SENT;
    em_id     = q_id;
    em_lt     = lt_use;
    em_last   = 1'b1;
    more      = fin.has_best && (n_res < MAX_RESULTS);
    to_flush  = 1'b0;
    do_insert = 1'b0;
    wr        = '0;
    wr_idx    = fin_free;

    // tick pop of the chosen entry
    lt_dead  = fin.lt[LT_W-1] || fin.lt == '0;
    send     = fin.is_local || {1'b0, q_rc} < prob;
    pop_code = EV_HELD;
    delay    = LT_W'(fin.lt) + LT_W'(hold);
    if (lt_dead) begin
      pop_code = EV_EXPIRED;
    end else if (fin.sends < max_bc) begin
      pop_code = send ? EV_SENT : EV_SUPPRESSED;
      if (fin.lt > $signed({5'd0, period_eff})) begin
        delay = LT_W'(period_eff);
      end
    end

    if (state == S_FLUSH) begin
      need_emit = 1'b1;
      em_code   = pend_code;
      em_id     = pend_id;
      em_lt     = pend_lt;
    end else if (q_req == REQ_TICK) begin
      need_emit = pend_valid;
      em_code   = pend_code;
      em_id     = pend_id;
      em_lt     = pend_lt;
      em_last   = !more;
      if (more) begin
        wr_idx        = fin_best;
        wr.en         = 1'b1;
        wr.valid      = !lt_dead;
        wr.keep_order = 1'b1;
        wr.id         = fin.id;
        wr.due        = now + TIME_W'(delay);
        wr.lt         = fin.lt - $signed(delay);
        wr.sends      = fin.sends;
        wr.is_local   = fin.is_local;
        if (!lt_dead && fin.sends < max_bc) begin
          wr.sends    = fin.sends + 8'd1;
          wr.is_local = 1'b0;
        end
      end
    end else if (q_req == REQ_LOCAL) begin
      if (init_lt == '0) begin
        need_emit = 1'b1;
        em_code   = EV_DEAD;
      end else if (!fin.has_free) begin
        need_emit = 1'b1;
        em_code   = EV_FULL;
      end else begin
        do_insert = 1'b1;
      end
    end else begin
      need_emit = 1'b1;
      if (fin.match) begin
        em_code = EV_DUPLICATE;
      end else if (q_lt[LT_W-1] || q_lt == '0) begin
        em_code = EV_DEAD;
      end else if (!fin.has_free) begin
        em_code  = EV_FULL;
        em_last  = 1'b0;
        to_flush = 1'b1;
      end else begin
        do_insert = 1'b1;
        em_code   = EV_DELIVER;
        em_lt     = lt_use - $signed({5'd0, back});
      end
    end

    if (do_insert) begin
      wr.en       = 1'b1;
      wr.valid    = 1'b1;
      wr.id       = q_id;
      wr.due      = now + TIME_W'(back);
      wr.order    = icnt;
      wr.lt       = lt_use - $signed({5'd0, back});
      wr.sends    = '0;
      wr.is_local = (q_req == REQ_LOCAL);
    end

    go   = (state == S_DECIDE || state == S_FLUSH) && (!need_emit || ok);
    emit = go && need_emit;
    if (!go) begin
      wr.en = 1'b0;
    end
  end

  assign in_ch.ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now        <= '0;
      icnt       <= '0;
      scan_cnt   <= '0;
      n_res      <= '0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            scan_cnt   <= '0;
            n_res      <= '0;
            pend_valid <= 1'b0;
            if (req_t'(in_ch.req_type) == REQ_TICK) begin
              now <= now + 32'd1;
            end
            if (req_t'(in_ch.req_type) != REQ_NONE) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == IW'(TABLE_DEPTH - 1)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (go) begin
            scan_cnt <= '0;
            if (do_insert) begin
              icnt <= icnt + 32'd1;
            end
            if (q_req == REQ_TICK) begin
              if (more) begin
                pend_valid <= 1'b1;
                n_res      <= n_res + 5'd1;
                state      <= S_SCAN;
              end else begin
                pend_valid <= 1'b0;
                state      <= S_IDLE;
              end
            end else if (to_flush) begin
              state <= S_FLUSH;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_FLUSH: begin
          if (go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // latched request and pending result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_ch.valid) begin
      q_req <= req_t'(in_ch.req_type);
      q_id  <= in_ch.msg_id;
      q_lt  <= in_ch.lifetime_in;
      q_rb  <= in_ch.rand_backoff;
      q_rc  <= in_ch.rand_coin;
    end
    if (state == S_DECIDE && go) begin
      if (q_req == REQ_TICK) begin
        pend_code <= pop_code;
        pend_id   <= fin.id;
        pend_lt   <= fin.lt;
      end else begin
        pend_code <= EV_DELIVER;
        pend_id   <= q_id;
        pend_lt   <= q_lt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_code <= em_code;
      out_id   <= em_id;
      out_lt   <= em_lt;
      out_last <= em_last;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.event_code   = out_code;
  assign out_ch.msg_out_id   = out_id;
  assign out_ch.lifetime_out = out_lt;
  assign out_ch.last_result  = out_last;

endmodule

/* sim/gfs_scheduler_checker.sv */
`timescale 1ns / 1ps

// Watches the request and result channels, keeps its own copy of the
// broadcast table and compares every result against the expected stream.
module gfs_scheduler_checker import gfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  gfs_in_if           in_mon,
  gfs_out_if          out_mon,
  output int          fail_count,
  output int          pending
);

  localparam int DEPTH = 16;

  typedef struct {
    event_t             code;
    logic [31:0]        id;
    logic [20:0]        lt;
    logic               last;
  } result_t;

  result_t expected_results[$];

  // configuration copy
  logic [15:0] period;
  logic [7:0]  max_bc;
  logic [16:0] prob;
  logic [15:0] hold;
  logic [15:0] max_fb;
  logic [19:0] init_life;

  // table copy
  logic        tab_valid [DEPTH];
  logic [31:0] tab_id    [DEPTH];
  logic [31:0] tab_due   [DEPTH];
  logic [31:0] tab_ord   [DEPTH];
  int          tab_lt    [DEPTH];
  logic [7:0]  tab_sends [DEPTH];
  logic        tab_local [DEPTH];
  logic [31:0] now_ticks;
  logic [31:0] ins_cnt;

  function automatic longint unsigned eff_period();
    return (period == 0) ? 1 : period;
  endfunction

  task automatic add_result(event_t code, logic [31:0] id, int lt);
    result_t r;
    r.code = code;
    r.id   = id;
    r.lt   = lt[20:0];
    r.last = 1'b0;
    expected_results.push_back(r);
  endtask

  function automatic int free_slot();
    for (int i = 0; i < DEPTH; i++)
      if (!tab_valid[i]) return i;
    return -1;
  endfunction

  function automatic bit id_known(logic [31:0] id);
    for (int i = 0; i < DEPTH; i++)
      if (tab_valid[i] && tab_id[i] == id) return 1;
    return 0;
  endfunction

  // store a new entry with its first backoff, give back the lifetime left
  task automatic store_entry(int slot, logic [31:0] id, int lt, bit loc,
                             logic [15:0] rb, output int left);
    longint unsigned bound;
    longint unsigned back;
    bound = eff_period();
    if (max_fb < bound) bound = max_fb;
    if (longint'(lt) < longint'(bound)) bound = lt;
    back = (bound * rb) / 65535;
    tab_valid[slot] = 1'b1;
    tab_id[slot]    = id;
    tab_due[slot]   = now_ticks + back[31:0];
    tab_ord[slot]   = ins_cnt;
    ins_cnt         = ins_cnt + 1;
    tab_lt[slot]    = lt - int'(back);
    tab_sends[slot] = '0;
    tab_local[slot] = loc;
    left = tab_lt[slot];
  endtask

  // oldest due entry, ties broken by insertion order
  function automatic int oldest_due();
    int best;
    logic [31:0] best_age, best_ord, age, ord;
    best = -1;
    best_age = '0;
    best_ord = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!tab_valid[i]) continue;
      age = now_ticks - tab_due[i];
      if (age[31]) continue;
      ord = ins_cnt - tab_ord[i];
      if (best < 0 || age > best_age || (age == best_age && ord > best_ord)) begin
        best = i;
        best_age = age;
        best_ord = ord;
      end
    end
    return best;
  endfunction

  task automatic requeue(int i, longint unsigned delay);
    tab_due[i] = now_ticks + delay[31:0];
    tab_lt[i]  = tab_lt[i] - int'(delay);
  endtask

  task automatic run_tick(logic [15:0] coin);
    int n, i, lt;
    bit send;
    n = 0;
    now_ticks = now_ticks + 1;
    while (n < DEPTH) begin
      i = oldest_due();
      if (i < 0) break;
      lt = tab_lt[i];
      if (lt <= 0) begin
        tab_valid[i] = 1'b0;
        add_result(EV_EXPIRED, tab_id[i], lt);
      end else if (tab_sends[i] < max_bc) begin
        send = tab_local[i] || ({1'b0, coin} < prob);
        tab_sends[i] = tab_sends[i] + 1;
        tab_local[i] = 1'b0;
        if (longint'(lt) > longint'(eff_period())) requeue(i, eff_period());
        else requeue(i, lt + hold);
        add_result(send ? EV_SENT : EV_SUPPRESSED, tab_id[i], lt);
      end else begin
        requeue(i, lt + hold);
        add_result(EV_HELD, tab_id[i], lt);
      end
      n++;
    end
  endtask

  task automatic predict_request(req_t req, logic [31:0] id, logic [20:0] lt_bits,
                                 logic [15:0] rb, logic [15:0] rc);
    int before_n, lt_in, lt, slot, left;
    before_n = expected_results.size();
    lt_in = int'($signed(lt_bits));
    case (req)
      REQ_TICK: begin
        run_tick(rc);
      end
      REQ_LOCAL: begin
        lt = int'(init_life);
        if (lt <= 0) begin
          add_result(EV_DEAD, id, lt);
        end else begin
          slot = free_slot();
          if (slot < 0) add_result(EV_FULL, id, lt);
          else store_entry(slot, id, lt, 1'b1, rb, left);
        end
      end
      REQ_RECEIVE: begin
        if (id_known(id)) begin
          add_result(EV_DUPLICATE, id, lt_in);
        end else if (lt_in <= 0) begin
          add_result(EV_DEAD, id, lt_in);
        end else begin
          slot = free_slot();
          if (slot < 0) begin
            add_result(EV_FULL, id, lt_in);
            add_result(EV_DELIVER, id, lt_in);
          end else begin
            store_entry(slot, id, lt_in, 1'b0, rb, left);
            add_result(EV_DELIVER, id, left);
          end
        end
      end
      default: begin
      end
    endcase
    if (expected_results.size() > before_n)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      period    <= 16'd1000;
      max_bc    <= 8'd1;
      prob      <= 17'd32768;
      hold      <= 16'd1000;
      max_fb    <= 16'd1000;
      init_life <= 20'd10000;
      for (int i = 0; i < DEPTH; i++) tab_valid[i] = 1'b0;
      now_ticks = '0;
      ins_cnt   = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // compare first: a result at this edge belongs to an earlier request
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result code=%0d id=%h lt=%h last=%0d", $time,
                   out_mon.event_code, out_mon.msg_out_id, out_mon.lifetime_out,
                   out_mon.last_result);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_mon.event_code !== exp_r.code || out_mon.msg_out_id !== exp_r.id ||
              out_mon.lifetime_out !== exp_r.lt || out_mon.last_result !== exp_r.last) begin
            $display("%0t: mismatch expected code=%0d id=%h lt=%h last=%0d", $time,
                     exp_r.code, exp_r.id, exp_r.lt, exp_r.last);
            $display("%0t:          actual   code=%0d id=%h lt=%h last=%0d", $time,
                     out_mon.event_code, out_mon.msg_out_id, out_mon.lifetime_out,
                     out_mon.last_result);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_request(req_t'(in_mon.req_type), in_mon.msg_id, in_mon.lifetime_in,
                        in_mon.rand_backoff, in_mon.rand_coin);
      if (cfg_we) begin
        case (cfg_index)
          CFG_PERIOD:   period    <= cfg_data[15:0];
          CFG_MAX_BC:   max_bc    <= cfg_data[7:0];
          CFG_PROB:     prob      <= cfg_data[16:0];
          CFG_HOLD:     hold      <= cfg_data[15:0];
          CFG_MAX_FB:   max_fb    <= cfg_data[15:0];
          CFG_LIFETIME: init_life <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import gfs_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [19:0] cfg_data;
  int          fail_count;
  int          pending;
  int          items_sent;
  int          idle_cycles;
  logic        stim_done;

  gfs_in_if  in_ch ();
  gfs_out_if out_ch ();

  gossip_forward_scheduler_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  gfs_scheduler_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one request transaction; starts and ends at a falling edge
  task automatic push(req_t req, logic [31:0] id, int lt, logic [15:0] rb, logic [15:0] rc);
    in_ch.valid        = 1'b1;
    in_ch.req_type     = req;
    in_ch.msg_id       = id;
    in_ch.lifetime_in  = lt[20:0];
    in_ch.rand_backoff = rb;
    in_ch.rand_coin    = rc;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (req != REQ_NONE) items_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // wait for all results, then for a request that made none to finish
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic configure(int per, int mbc, int pr, int hd, int fb, int life);
    wait_idle();
    write_reg(CFG_PERIOD, per);
    write_reg(CFG_MAX_BC, mbc);
    write_reg(CFG_PROB, pr);
    write_reg(CFG_HOLD, hd);
    write_reg(CFG_MAX_FB, fb);
    write_reg(CFG_LIFETIME, life);
  endtask

  // random requests in bursts; lt_max bounds received lifetimes unless full_lt
  task automatic random_phase(int count, int lt_max, bit full_lt);
    int done, burst, roll, lt;
    logic [31:0] id;
    logic [15:0] rb;
    done = 0;
    while (done < count) begin
      burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        rb = ($urandom_range(0, 7) == 0) ? {16{$urandom_range(0, 1) == 1}} : $urandom;
        if (roll < 45) begin
          push(REQ_TICK, $urandom, $urandom, rb, $urandom);
        end else if (roll < 62) begin
          push(REQ_LOCAL, $urandom, $urandom, rb, $urandom);
        end else if (roll < 95) begin
          id = ($urandom_range(0, 1) == 0) ? 32'hA000_0000 + $urandom_range(0, 7) : $urandom;
          if (full_lt) lt = int'($signed(21'($urandom)));
          else if ($urandom_range(0, 9) == 0) lt = -int'($urandom_range(0, 1048576));
          else lt = $urandom_range(0, lt_max);
          push(REQ_RECEIVE, id, lt, rb, $urandom);
        end else begin
          push(REQ_NONE, $urandom, $urandom, $urandom, $urandom);
          done--;
        end
        done++;
      end
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
  endtask

  // receiver: stall pattern of its own, plus one long hold-off under load
  initial begin
    int seg_len, mode;
    bit held;
    out_ch.ready = 1'b0;
    held = 0;
    @(negedge rst);
    forever begin
      seg_len = $urandom_range(20, 200);
      mode = $urandom_range(0, 2);
      repeat (seg_len) begin
        @(negedge clk);
        if (!held && items_sent >= 150) begin
          held = 1;
          out_ch.ready = 1'b0;
          repeat (400) @(negedge clk);
        end
        case (mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = $urandom_range(0, 1);
          default: out_ch.ready = ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_TICK;
    in_ch.msg_id = '0;
    in_ch.lifetime_in = '0;
    in_ch.rand_backoff = '0;
    in_ch.rand_coin = '0;
    items_sent = 0;
    idle_cycles = 0;
    stim_done = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: short lifetimes so the table keeps turning over
    configure(4, 2, 32768, 3, 4, 12);
    push(REQ_LOCAL, 32'h0000_0000, 0, 16'h0000, 16'h0000);
    push(REQ_LOCAL, 32'hFFFF_FFFF, 0, 16'hFFFF, 16'hFFFF);
    push(REQ_RECEIVE, 32'h1, 1, 16'h0000, 16'h0000);
    push(REQ_RECEIVE, 32'h1, 5, 16'h0000, 16'h0000);
    push(REQ_RECEIVE, 32'h2, 0, 16'h0000, 16'h0000);
    push(REQ_RECEIVE, 32'h3, -1048576, 16'h0000, 16'h0000);
    push(REQ_RECEIVE, 32'h4, 12, 16'hFFFF, 16'hFFFF);
    push(REQ_NONE, 32'h5, 3, 16'h1234, 16'h0000);
    for (int k = 0; k < 12; k++)
      push(REQ_RECEIVE, 32'h10 + k, 12, 16'h0000, 16'h0);
    // table is full now
    push(REQ_RECEIVE, 32'h40, 9, 16'h0000, 16'h0000);
    push(REQ_LOCAL, 32'h41, 0, 16'h0000, 16'h0000);
    push(REQ_TICK, 0, 0, 0, 16'h0000);
    push(REQ_TICK, 0, 0, 0, 16'hFFFF);
    push(REQ_TICK, 0, 0, 0, 16'h7FFF);
    push(REQ_TICK, 0, 0, 0, 16'h8000);

    // all-zero settings: zero period acts as one, local lifetime zero is dead
    configure(0, 0, 0, 0, 0, 0);
    random_phase(60, 20, 0);
    configure(3, 3, 65536, 2, 3, 15);
    random_phase(100, 30, 0);
    configure(5, 255, 20000, 1, 65535, 25);
    random_phase(100, 40, 0);
    configure(2, 1, 65535, 4, 2, 1);
    random_phase(100, 10, 0);
    // largest settings last: entries stay put and the table fills
    configure(65535, 255, 65536, 65535, 65535, 1048575);
    random_phase(50, 0, 1);

    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    stim_done = 1'b1;
    repeat (400) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
